// ===== hw/rtl/tcw_pkg.sv =====
// Shared constants, codes and widths of the text console writer.
`timescale 1ns / 1ps
package tcw_pkg;

	localparam int COLUMNS    = 80;
	localparam int ROWS       = 25;
	localparam int CELL_COUNT = ROWS * COLUMNS;
	localparam int ADDR_W     = $clog2(CELL_COUNT);
	localparam int ROW_W      = (ROWS > 2) ? $clog2(ROWS) : 1;
	localparam int COL_W      = $clog2(COLUMNS);
	localparam int CELL_W     = 16;

	localparam int OPC_W      = 2;
	localparam int CHAR_W     = 8;
	localparam int COLOR_W    = 8;
	localparam int IDX_W      = 11;
	localparam int ROW_OUT_W  = 5;
	localparam int COL_OUT_W  = 7;
	localparam int POS_OUT_W  = 11;

	localparam logic [OPC_W-1:0] OP_PUT   = 2'd0;
	localparam logic [OPC_W-1:0] OP_CLEAR = 2'd1;
	localparam logic [OPC_W-1:0] OP_READ  = 2'd2;

	localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'd8;
	localparam logic [CHAR_W-1:0] CH_TAB       = 8'd9;
	localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'd10;
	localparam logic [CHAR_W-1:0] CH_SPACE     = 8'd32;

	localparam logic [COLOR_W-1:0] RESET_COLOR = 8'd10;
	localparam logic [CELL_W-1:0]  BLANK_RESET = {RESET_COLOR, CH_SPACE};

endpackage

// ===== hw/rtl/tcw_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module tcw_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 2000
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== hw/rtl/text_console_writer.sv =====
// Top level of the text console writer: cursor control and frame buffer sequencer.
// Put, backspace, newline without scroll and out-of-range reads go straight to the response
//   state; a read passes through S_READ first; a tab blanks the skipped cells, at most 4, in S_TAB.
// Scroll: S_SCRL copies the rows up through the one RAM port pair, S_SDRN drains the last copy,
//   then S_BLNK blanks the bottom row. Clear: S_BLNK blanks every cell.
// Items are taken one at a time.
// Reset: async, active low; then a clearing pass fills the buffer with blanks.
`timescale 1ns / 1ps
module text_console_writer
	import tcw_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,

	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [COLOR_W-1:0]   text_color,

	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [OPC_W-1:0]     opcode,
	input  logic [CHAR_W-1:0]    char_code,
	input  logic [IDX_W-1:0]     cell_index,

	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [ROW_OUT_W-1:0] cursor_row,
	output logic [COL_OUT_W-1:0] cursor_column,
	output logic [POS_OUT_W-1:0] cursor_position,
	output logic                 scrolled,
	output logic [CELL_W-1:0]    cell_value
);

	typedef enum logic [7:0] {
		S_INIT = 8'b0000_0001,
		S_IDLE = 8'b0000_0010,
		S_TAB  = 8'b0000_0100,
		S_SCRL = 8'b0000_1000,
		S_SDRN = 8'b0001_0000,
		S_BLNK = 8'b0010_0000,
		S_READ = 8'b0100_0000,
		S_RESP = 8'b1000_0000
	} state_t;

	localparam int CW1 = COL_W + 1;

	state_t              state_q;
	logic [COLOR_W-1:0]  text_color_q;
	logic [ROW_W-1:0]    row_q;
	logic [COL_W-1:0]    col_q;
	logic [ADDR_W-1:0]   rowbase_q;
	logic [ADDR_W-1:0]   ptr_q;
	logic                scrolled_q;
	logic                pend_s1;
	logic [ADDR_W-1:0]   copy_addr_s1;
	logic [CW1-1:0]      tab_tgt_q;
	logic [CELL_W-1:0]   cell_q;
	logic                out_valid_q;

	logic                accept;
	logic                load_out;
	logic [ADDR_W-1:0]   addr_cur;
	logic [CW1-1:0]      col_ext;
	logic [CW1-1:0]      col_inc;
	logic [CW1-1:0]      tab_raw;
	logic [CW1-1:0]      tab_tgt;
	logic                at_last_row;
	logic                idx_ok;
	logic                is_special;
	logic                wrap;
	logic                ptr_last;
	logic [CELL_W-1:0]   blank_cur;

	logic                ram_we;
	logic [ADDR_W-1:0]   ram_waddr;
	logic [CELL_W-1:0]   ram_wdata;
	logic                ram_re;
	logic [ADDR_W-1:0]   ram_raddr;
	logic [CELL_W-1:0]   ram_rdata;

	assign cfg_ready   = 1'b1;
	assign in_ready    = (state_q == S_IDLE);
	assign accept      = in_valid && in_ready;
	assign load_out    = (state_q == S_RESP) && (!out_valid_q || out_ready);

	assign addr_cur    = rowbase_q + ADDR_W'(col_q);
	assign col_ext     = CW1'(col_q);
	assign col_inc     = col_ext + CW1'(1);
	assign tab_raw     = (col_ext + CW1'(4)) & ~CW1'(3);
	assign tab_tgt     = (tab_raw >= CW1'(COLUMNS)) ? CW1'(COLUMNS - 1) : tab_raw;
	assign at_last_row = (row_q == ROW_W'(ROWS - 1));
	assign idx_ok      = (32'(cell_index) < 32'(CELL_COUNT));
	assign is_special  = (char_code == CH_NEWLINE) || (char_code == CH_BACKSPACE) ||
	                     (char_code == CH_TAB);
	assign wrap        = (char_code == CH_NEWLINE) ||
	                     (!is_special && (col_inc == CW1'(COLUMNS)));
	assign ptr_last    = (ptr_q == ADDR_W'(CELL_COUNT - 1));
	assign blank_cur   = {text_color_q, CH_SPACE};

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = ptr_q;
		ram_wdata = blank_cur;
		ram_re    = 1'b0;
		ram_raddr = ptr_q;
		case (state_q)
			S_INIT: begin
				ram_we    = 1'b1;
				ram_wdata = BLANK_RESET;
			end
			S_IDLE: begin
				if (accept && opcode == OP_PUT) begin
					if (char_code == CH_BACKSPACE) begin
						ram_we    = (col_q != '0);
						ram_waddr = addr_cur - ADDR_W'(1);
					end else if (!is_special) begin
						ram_we    = 1'b1;
						ram_waddr = addr_cur;
						ram_wdata = {text_color_q, char_code};
					end
				end
				if (accept && opcode == OP_READ && idx_ok) begin
					ram_re    = 1'b1;
					ram_raddr = ADDR_W'(cell_index);
				end
			end
			S_TAB: begin
				ram_we    = 1'b1;
				ram_waddr = addr_cur;
			end
			S_SCRL: begin
				ram_re = 1'b1;
			end
			S_BLNK: begin
				ram_we = 1'b1;
			end
			default: begin
			end
		endcase
		if (pend_s1) begin
			ram_we    = 1'b1;
			ram_waddr = copy_addr_s1;
			ram_wdata = ram_rdata;
		end
	end

	tcw_ram #(
		.WIDTH(CELL_W),
		.DEPTH(CELL_COUNT)
	) u_frame (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			text_color_q <= RESET_COLOR;
		end else if (cfg_valid && cfg_ready) begin
			text_color_q <= text_color;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_INIT;
			row_q      <= '0;
			col_q      <= '0;
			rowbase_q  <= '0;
			ptr_q      <= '0;
			scrolled_q <= 1'b0;
			pend_s1    <= 1'b0;
		end else begin
			pend_s1 <= (state_q == S_SCRL);
			case (state_q)
				S_INIT: begin
					ptr_q <= ptr_q + ADDR_W'(1);
					if (ptr_last) begin
						ptr_q   <= '0;
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						scrolled_q <= 1'b0;
						state_q    <= S_RESP;
						case (opcode)
							OP_PUT: begin
								if (wrap) begin
									col_q <= '0;
									if (at_last_row) begin
										scrolled_q <= 1'b1;
										ptr_q      <= ADDR_W'(COLUMNS);
										state_q    <= S_SCRL;
									end else begin
										row_q     <= row_q + ROW_W'(1);
										rowbase_q <= rowbase_q + ADDR_W'(COLUMNS);
									end
								end else if (char_code == CH_BACKSPACE) begin
									if (col_q != '0) begin
										col_q <= col_q - COL_W'(1);
									end
								end else if (char_code == CH_TAB) begin
									if (col_ext < tab_tgt) begin
										state_q <= S_TAB;
									end
								end else begin
									col_q <= col_inc[COL_W-1:0];
								end
							end
							OP_CLEAR: begin
								row_q     <= '0;
								col_q     <= '0;
								rowbase_q <= '0;
								ptr_q     <= '0;
								state_q   <= S_BLNK;
							end
							OP_READ: begin
								if (idx_ok) begin
									state_q <= S_READ;
								end
							end
							default: begin
							end
						endcase
					end
				end
				S_TAB: begin
					col_q <= col_inc[COL_W-1:0];
					if (col_inc == tab_tgt_q) begin
						state_q <= S_RESP;
					end
				end
				S_SCRL: begin
					ptr_q <= ptr_q + ADDR_W'(1);
					if (ptr_last) begin
						state_q <= S_SDRN;
					end
				end
				S_SDRN: begin
					ptr_q   <= ADDR_W'((ROWS - 1) * COLUMNS);
					state_q <= S_BLNK;
				end
				S_BLNK: begin
					ptr_q <= ptr_q + ADDR_W'(1);
					if (ptr_last) begin
						state_q <= S_RESP;
					end
				end
				S_READ: begin
					state_q <= S_RESP;
				end
				S_RESP: begin
					if (load_out) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		copy_addr_s1 <= ptr_q - ADDR_W'(COLUMNS);
		if (accept) begin
			tab_tgt_q <= tab_tgt;
			cell_q    <= '0;
		end
		if (state_q == S_READ) begin
			cell_q <= ram_rdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			cursor_row      <= ROW_OUT_W'(row_q);
			cursor_column   <= COL_OUT_W'(col_q);
			cursor_position <= POS_OUT_W'(addr_cur);
			scrolled        <= scrolled_q;
			cell_value      <= cell_q;
		end
	end

	assign out_valid = out_valid_q;

endmodule

// ===== hw/rtl/tcw_checker.sv =====
// Port-level checker of the text console writer and its bind to the top level.
`timescale 1ns / 1ps
module tcw_checker
	import tcw_pkg::*;
(
	input logic                 clk,
	input logic                 arst_n,
	input logic                 in_valid,
	input logic                 in_ready,
	input logic                 out_valid,
	input logic                 out_ready,
	input logic [ROW_OUT_W-1:0] cursor_row,
	input logic [COL_OUT_W-1:0] cursor_column,
	input logic [POS_OUT_W-1:0] cursor_position,
	input logic                 scrolled,
	input logic [CELL_W-1:0]    cell_value
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(cursor_row) &&
		$stable(cursor_column) && $stable(cursor_position) && $stable(scrolled) &&
		$stable(cell_value))
		else $error("result changed while stalled");

	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("second transfer taken while an item is in work");

	a_scroll_home: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && scrolled |-> cursor_row == ROW_OUT_W'(ROWS - 1) && cursor_column == '0)
		else $error("scroll reported off the start of the bottom row");

	a_col_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> 32'(cursor_column) < 32'(COLUMNS) && 32'(cursor_row) < 32'(ROWS))
		else $error("cursor outside the screen");

endmodule

bind text_console_writer tcw_checker u_tcw_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.in_valid       (in_valid),
	.in_ready       (in_ready),
	.out_valid      (out_valid),
	.out_ready      (out_ready),
	.cursor_row     (cursor_row),
	.cursor_column  (cursor_column),
	.cursor_position(cursor_position),
	.scrolled       (scrolled),
	.cell_value     (cell_value)
);

// ===== tb/text_console_writer_tb.sv =====
// Self-checking testbench for the text console writer: directed table plus random bursts.
`timescale 1ns / 1ps
module text_console_writer_tb;
	import tcw_pkg::*;

	localparam logic [OPC_W-1:0] OP_UNUSED = 2'd3;
	localparam int DIR_ROWS = 22;

	typedef struct packed {
		logic [ROW_OUT_W-1:0] row;
		logic [COL_OUT_W-1:0] col;
		logic [POS_OUT_W-1:0] pos;
		logic                 scr;
		logic [CELL_W-1:0]    cval;
	} console_result_t;

	typedef struct packed {
		logic [OPC_W-1:0]  op;
		logic [CHAR_W-1:0] ch;
		logic [IDX_W-1:0]  idx;
		logic [7:0]        reps;
		logic              fixed;
		console_result_t   res;
	} stim_row_t;

	// fixed rows carry their own expectation; the rest go through the predictor
	localparam stim_row_t DIR_TAB [DIR_ROWS] = '{
		'{OP_READ,   8'h00,        11'd0,    8'd1,  1'b1, '{5'd0, 7'd0, 11'd0, 1'b0, 16'h0A20}},
		'{OP_READ,   8'h00,        11'd1999, 8'd1,  1'b1, '{5'd0, 7'd0, 11'd0, 1'b0, 16'h0A20}},
		'{OP_READ,   8'h00,        11'd2047, 8'd1,  1'b1, '{5'd0, 7'd0, 11'd0, 1'b0, 16'h0000}},
		'{OP_UNUSED, 8'hFF,        11'd2047, 8'd1,  1'b1, '{5'd0, 7'd0, 11'd0, 1'b0, 16'h0000}},
		'{OP_PUT,    8'h41,        11'd0,    8'd1,  1'b1, '{5'd0, 7'd1, 11'd1, 1'b0, 16'h0000}},
		'{OP_READ,   8'h00,        11'd0,    8'd1,  1'b1, '{5'd0, 7'd1, 11'd1, 1'b0, 16'h0A41}},
		'{OP_PUT,    CH_BACKSPACE, 11'd0,    8'd1,  1'b1, '{5'd0, 7'd0, 11'd0, 1'b0, 16'h0000}},
		'{OP_PUT,    CH_BACKSPACE, 11'd0,    8'd1,  1'b1, '{5'd0, 7'd0, 11'd0, 1'b0, 16'h0000}},
		'{OP_READ,   8'h00,        11'd0,    8'd1,  1'b1, '{5'd0, 7'd0, 11'd0, 1'b0, 16'h0A20}},
		'{OP_PUT,    8'hFF,        11'd0,    8'd1,  1'b0, '0},
		'{OP_PUT,    8'h00,        11'd0,    8'd1,  1'b0, '0},
		'{OP_PUT,    CH_TAB,       11'd0,    8'd1,  1'b0, '0},
		'{OP_PUT,    CH_NEWLINE,   11'd0,    8'd1,  1'b0, '0},
		'{OP_PUT,    8'h80,        11'd0,    8'd77, 1'b0, '0},
		'{OP_PUT,    CH_TAB,       11'd0,    8'd1,  1'b0, '0},
		'{OP_PUT,    CH_TAB,       11'd0,    8'd1,  1'b0, '0},
		'{OP_PUT,    8'h7E,        11'd0,    8'd1,  1'b0, '0},
		'{OP_READ,   8'h00,        11'd159,  8'd1,  1'b0, '0},
		'{OP_PUT,    CH_NEWLINE,   11'd0,    8'd23, 1'b0, '0},
		'{OP_READ,   8'h00,        11'd80,   8'd1,  1'b0, '0},
		'{OP_CLEAR,  8'h00,        11'd0,    8'd1,  1'b1, '{5'd0, 7'd0, 11'd0, 1'b0, 16'h0000}},
		'{OP_READ,   8'h00,        11'd1999, 8'd1,  1'b1, '{5'd0, 7'd0, 11'd0, 1'b0, 16'h0A20}}
	};

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [COLOR_W-1:0]   text_color;
	logic                 in_valid;
	logic                 in_ready;
	logic [OPC_W-1:0]     opcode;
	logic [CHAR_W-1:0]    char_code;
	logic [IDX_W-1:0]     cell_index;
	logic                 out_valid;
	logic                 out_ready;
	logic [ROW_OUT_W-1:0] cursor_row;
	logic [COL_OUT_W-1:0] cursor_column;
	logic [POS_OUT_W-1:0] cursor_position;
	logic                 scrolled;
	logic [CELL_W-1:0]    cell_value;

	logic [CELL_W-1:0]  shadow_cells [CELL_COUNT];
	int                 shadow_row;
	int                 shadow_col;
	logic [COLOR_W-1:0] shadow_color;
	console_result_t    pending_results [$];
	int                 failures;
	bit                 no_idle;
	int                 hold_left;

	text_console_writer dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.text_color      (text_color),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.opcode          (opcode),
		.char_code       (char_code),
		.cell_index      (cell_index),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.cursor_row      (cursor_row),
		.cursor_column   (cursor_column),
		.cursor_position (cursor_position),
		.scrolled        (scrolled),
		.cell_value      (cell_value)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#80_000_000;
		$display("simulation failed");
		$finish;
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (no_idle || r < 60) begin
			return 0;
		end
		if (r < 92) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(10, 40);
	endfunction

	function automatic void blank_screen();
		for (int i = 0; i < CELL_COUNT; i++) begin
			shadow_cells[i] = {shadow_color, CH_SPACE};
		end
	endfunction

	function automatic bit advance_row();
		shadow_col = 0;
		shadow_row++;
		if (shadow_row < ROWS) begin
			return 1'b0;
		end
		shadow_row = ROWS - 1;
		for (int i = 0; i < (ROWS - 1) * COLUMNS; i++) begin
			shadow_cells[i] = shadow_cells[i + COLUMNS];
		end
		for (int i = (ROWS - 1) * COLUMNS; i < CELL_COUNT; i++) begin
			shadow_cells[i] = {shadow_color, CH_SPACE};
		end
		return 1'b1;
	endfunction

	function automatic console_result_t apply_console_item(logic [OPC_W-1:0] op,
			logic [CHAR_W-1:0] ch, logic [IDX_W-1:0] idx);
		console_result_t res;
		int target;
		int lin;
		res = '0;
		case (op)
			OP_PUT: begin
				if (ch == CH_NEWLINE) begin
					res.scr = advance_row();
				end else if (ch == CH_BACKSPACE) begin
					if (shadow_col > 0) begin
						shadow_col--;
						shadow_cells[shadow_row * COLUMNS + shadow_col] = {shadow_color, CH_SPACE};
					end
				end else if (ch == CH_TAB) begin
					target = (shadow_col + 4) & ~3;
					if (target >= COLUMNS) begin
						target = COLUMNS - 1;
					end
					while (shadow_col < target) begin
						shadow_cells[shadow_row * COLUMNS + shadow_col] = {shadow_color, CH_SPACE};
						shadow_col++;
					end
				end else begin
					shadow_cells[shadow_row * COLUMNS + shadow_col] = {shadow_color, ch};
					shadow_col++;
					if (shadow_col >= COLUMNS) begin
						res.scr = advance_row();
					end
				end
			end
			OP_CLEAR: begin
				shadow_row = 0;
				shadow_col = 0;
				blank_screen();
			end
			OP_READ: begin
				if (idx < CELL_COUNT) begin
					res.cval = shadow_cells[idx];
				end
			end
			default: begin
			end
		endcase
		lin = shadow_row * COLUMNS + shadow_col;
		res.row = shadow_row[ROW_OUT_W-1:0];
		res.col = shadow_col[COL_OUT_W-1:0];
		res.pos = lin[POS_OUT_W-1:0];
		return res;
	endfunction

	task automatic send_item(input logic [OPC_W-1:0] op, input logic [CHAR_W-1:0] ch,
			input logic [IDX_W-1:0] idx, input bit use_fixed, input console_result_t fixed);
		int gap;
		console_result_t res;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid   <= 1'b1;
		opcode     <= op;
		char_code  <= ch;
		cell_index <= idx;
		res = apply_console_item(op, ch, idx);
		pending_results.push_back(use_fixed ? fixed : res);
		@(posedge clk);
		while (!in_ready) @(posedge clk);
	endtask

	task automatic write_color(input logic [COLOR_W-1:0] color);
		repeat (pick_gap()) @(posedge clk);
		cfg_valid  <= 1'b1;
		text_color <= color;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid    <= 1'b0;
		shadow_color  = color;
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic run_random_phase(input int count);
		int issued;
		int kind;
		int len;
		int idx;
		issued = 0;
		while (issued < count) begin
			kind = $urandom_range(0, 99);
			if (kind < 35) begin
				len = $urandom_range(1, 90);
				repeat (len) send_item(OP_PUT, CHAR_W'($urandom_range(0, 255)), '0, 1'b0, '0);
			end else if (kind < 50) begin
				len = $urandom_range(1, 4);
				repeat (len) send_item(OP_PUT, CH_TAB, '0, 1'b0, '0);
			end else if (kind < 60) begin
				len = $urandom_range(1, 6);
				repeat (len) send_item(OP_PUT, CH_BACKSPACE, '0, 1'b0, '0);
			end else if (kind < 70) begin
				len = $urandom_range(1, 3);
				repeat (len) send_item(OP_PUT, CH_NEWLINE, '0, 1'b0, '0);
			end else if (kind < 88) begin
				len = 1;
				kind = $urandom_range(0, 99);
				if (kind < 70) begin
					idx = shadow_row * COLUMNS + shadow_col - int'($urandom_range(0, 3));
					idx = (idx < 0) ? 0 : idx;
				end else if (kind < 95) begin
					idx = $urandom_range(0, CELL_COUNT - 1);
				end else begin
					idx = $urandom_range(CELL_COUNT, 2047);
				end
				send_item(OP_READ, CHAR_W'($urandom), IDX_W'(idx), 1'b0, '0);
			end else if (kind < 91) begin
				len = 1;
				send_item(OP_CLEAR, CHAR_W'($urandom), IDX_W'($urandom), 1'b0, '0);
			end else if (kind < 94) begin
				len = 1;
				send_item(OP_UNUSED, CHAR_W'($urandom), IDX_W'($urandom), 1'b0, '0);
			end else begin
				len = 1;
				send_item(OPC_W'($urandom), CHAR_W'($urandom), IDX_W'($urandom), 1'b0, '0);
			end
			issued += len;
		end
	endtask

	// response side: compare each transfer against the oldest pending result
	initial begin
		console_result_t want;
		out_ready <= 1'b0;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (out_valid && out_ready) begin
				if (pending_results.size() == 0) begin
					$error("unexpected result transfer: row %0d col %0d", cursor_row, cursor_column);
					failures++;
				end else begin
					want = pending_results.pop_front();
					if (cursor_row !== want.row) begin
						$error("cursor_row: expected %0d, got %0d", want.row, cursor_row);
						failures++;
					end
					if (cursor_column !== want.col) begin
						$error("cursor_column: expected %0d, got %0d", want.col, cursor_column);
						failures++;
					end
					if (cursor_position !== want.pos) begin
						$error("cursor_position: expected %0d, got %0d", want.pos, cursor_position);
						failures++;
					end
					if (scrolled !== want.scr) begin
						$error("scrolled: expected %0d, got %0d", want.scr, scrolled);
						failures++;
					end
					if (cell_value !== want.cval) begin
						$error("cell_value: expected %h, got %h", want.cval, cell_value);
						failures++;
					end
				end
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
				if ($urandom_range(0, 99) < 20) begin
					hold_left = pick_gap();
				end
			end
		end
	end

	initial begin
		logic [COLOR_W-1:0] phase_colors [5];
		stim_row_t row;
		failures     = 0;
		no_idle      = 1'b0;
		shadow_row   = 0;
		shadow_col   = 0;
		shadow_color = RESET_COLOR;
		blank_screen();
		arst_n     <= 1'b0;
		cfg_valid  <= 1'b0;
		text_color <= RESET_COLOR;
		in_valid   <= 1'b0;
		opcode     <= OP_PUT;
		char_code  <= '0;
		cell_index <= '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		for (int i = 0; i < DIR_ROWS; i++) begin
			row = DIR_TAB[i];
			repeat (row.reps) send_item(row.op, row.ch, row.idx, row.fixed, row.res);
		end
		drain_results();

		phase_colors = '{8'h00, 8'hFF, COLOR_W'($urandom), COLOR_W'($urandom), RESET_COLOR};
		for (int p = 0; p < 5; p++) begin
			no_idle = (p == 2);
			write_color(phase_colors[p]);
			run_random_phase(40);
			drain_results();
		end

		repeat (50) @(posedge clk);
		if (failures == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule

// ===== files.f =====
hw/rtl/tcw_pkg.sv
hw/rtl/tcw_ram.sv
hw/rtl/text_console_writer.sv
hw/rtl/tcw_checker.sv
tb/text_console_writer_tb.sv
